[sv/olar_pkg.sv]
// Package for the ordered list block: payload structs, status and action codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package olar_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_DUMP   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        t_action                   action;
        logic signed [DATA_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  item_value;
        t_status                   status;
        logic                      last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CLOSE,
        S_DUMP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic append;
        logic remove_start;
        logic search;
        logic close;
        logic dump_start;
        logic dump_step;
        logic empty;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic dump_last;
    } t_dp_stat;

endpackage

[sv/ordered_list_append_remove_top.sv]
// Top level of the ordered list block: controller plus entry-cell datapath.
// Depends on olar_pkg, olar_ctrl and olar_dp.
//
// Usage: present a command on i_item and raise start; it transfers at the
// rising edge where start is high and busy is low. Actions: append, remove
// first match, dump. Each result appears on o_result for exactly one cycle
// with o_valid high and transfers at the edge that ends that cycle; the
// receiver cannot stall, so results are never held.
// Sequencing per action:
//   append: result registered in the cycle after the transfer; busy stays
//           low, so a new command can follow in the next cycle.
//   remove: a compare cycle registers the per-cell match mask, a close-up
//           cycle shifts the cells and registers the result; busy stays
//           high through both, so the next command waits for the close-up.
//   dump:   one entry per cycle from the head cell while the chain rotates,
//           each stored entry once, busy meanwhile; an empty list gives one
//           registered empty-status result and busy stays low.
//   unused action code: ignored, no result.
// Reset (synchronous, active low) empties the list and drops any pending
// result; entry contents are not cleared.
module ordered_list_append_remove_top #(
    parameter int DEPTH = olar_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  olar_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_valid,
    output olar_pkg::t_out o_result
);

    olar_pkg::t_dp_cmd  w_cmd;
    olar_pkg::t_dp_stat w_stat;

    olar_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_stat   (w_stat),
        .busy     (busy),
        .o_cmd    (w_cmd)
    );

    olar_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (i_item.value),
        .o_stat   (w_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

[sv/olar_ctrl.sv]
// Controller state machine for the ordered list block.
// Depends on olar_pkg.
module olar_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  olar_pkg::t_action  i_action,
    input  olar_pkg::t_dp_stat i_stat,
    output logic               busy,
    output olar_pkg::t_dp_cmd  o_cmd
);

    olar_pkg::t_state r_state;
    olar_pkg::t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olar_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != olar_pkg::S_IDLE);

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            olar_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_action)
                        olar_pkg::ACT_APPEND: o_cmd.append = 1'b1;
                        olar_pkg::ACT_REMOVE: begin
                            o_cmd.remove_start = 1'b1;
                            n_state            = olar_pkg::S_SEARCH;
                        end
                        olar_pkg::ACT_DUMP: begin
                            if (i_stat.count_zero) begin
                                o_cmd.empty = 1'b1;
                            end else begin
                                o_cmd.dump_start = 1'b1;
                                n_state          = olar_pkg::S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            olar_pkg::S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = olar_pkg::S_CLOSE;
            end
            olar_pkg::S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = olar_pkg::S_IDLE;
            end
            olar_pkg::S_DUMP: begin
                o_cmd.dump_step = 1'b1;
                if (i_stat.dump_last) begin
                    n_state = olar_pkg::S_IDLE;
                end
            end
            default: n_state = olar_pkg::S_IDLE;
        endcase
    end

endmodule

[sv/olar_dp.sv]
// Datapath for the ordered list block: a chain of entry cells with per-cell
// compare, close-up shift, dump rotation and the result register. Depends on olar_pkg.
module olar_dp #(
    parameter int DEPTH = olar_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  olar_pkg::t_dp_cmd  i_cmd,
    input  logic signed [olar_pkg::DATA_W-1:0] i_value,
    output olar_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output olar_pkg::t_out     o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [olar_pkg::DATA_W-1:0] r_cell [DEPTH];
    logic signed [olar_pkg::DATA_W-1:0] n_cell [DEPTH];
    logic signed [olar_pkg::DATA_W-1:0] w_up   [DEPTH];
    logic signed [olar_pkg::DATA_W-1:0] r_key;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_remain;
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_pre;
    logic [DEPTH-1:0] r_shift;
    logic             r_any;
    logic             r_valid;
    olar_pkg::t_out   r_result;
    logic             w_full;

    assign w_full = (r_count == CW'(DEPTH));

    // Neighbor one cell away from the head; the top cell wraps to the head for rotation
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_up
            if (g < DEPTH - 1) begin : g_mid
                assign w_up[g] = r_cell[g+1];
            end else begin : g_top
                assign w_up[g] = r_cell[0];
            end
            // Compare each valid cell against the key
            assign w_match[g] = (r_cell[g] == r_key) && (CW'(g) < r_count);
            // First match at or below this cell
            assign w_pre[g] = |(w_match & ({DEPTH{1'b1}} >> (DEPTH - 1 - g)));
        end
    endgenerate

    // Next cell contents: append write, close-up shift, or dump rotation
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.append && (CW'(i) == r_count)) begin
                n_cell[i] = i_value;
            end else if (i_cmd.close && r_shift[i]) begin
                n_cell[i] = w_up[i];
            end else if (i_cmd.dump_step && (CW'(i) < r_count)) begin
                if (CW'(i) == r_count - CW'(1)) begin
                    n_cell[i] = r_cell[0];
                end else begin
                    n_cell[i] = w_up[i];
                end
            end
        end
    end

    // Advance the entry cells
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Latch the key and register the close-up mask
    always_ff @(posedge i_clk) begin
        if (i_cmd.remove_start) begin
            r_key <= i_value;
        end
        if (i_cmd.search) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_shift[i] <= w_pre[i] && ((CW'(i) + CW'(1)) < r_count);
            end
            r_any <= w_pre[DEPTH-1];
        end
    end

    // Track the entry count and the dump countdown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_remain <= '0;
        end else begin
            if (i_cmd.append && !w_full) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.close && r_any) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.dump_start) begin
                r_remain <= r_count;
            end else if (i_cmd.dump_step) begin
                r_remain <= r_remain - CW'(1);
            end
        end
    end

    // Register one result per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.append | i_cmd.close | i_cmd.dump_step | i_cmd.empty;
        end
        priority if (i_cmd.append) begin
            r_result.item_value <= i_value;
            r_result.status     <= w_full ? olar_pkg::ST_FULL : olar_pkg::ST_DONE;
            r_result.last       <= 1'b1;
        end else if (i_cmd.close) begin
            r_result.item_value <= r_key;
            r_result.status     <= r_any ? olar_pkg::ST_DONE : olar_pkg::ST_NOT_FOUND;
            r_result.last       <= 1'b1;
        end else if (i_cmd.dump_step) begin
            r_result.item_value <= r_cell[0];
            r_result.status     <= olar_pkg::ST_ENTRY;
            r_result.last       <= (r_remain == CW'(1));
        end else if (i_cmd.empty) begin
            r_result.item_value <= '0;
            r_result.status     <= olar_pkg::ST_EMPTY;
            r_result.last       <= 1'b1;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.dump_last  = (r_remain == CW'(1));
    assign o_valid           = r_valid;
    assign o_result          = r_result;

endmodule

[sv/olar_chk.sv]
// Port-level checker for the ordered list block, bound to the top level.
// Depends on olar_pkg and ordered_list_append_remove_top.
module olar_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input olar_pkg::t_in  i_item,
    input logic           busy,
    input logic           o_valid,
    input olar_pkg::t_out o_result
);

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // Append transfer yields its final result in the next cycle
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == olar_pkg::ACT_APPEND)
        |=> (o_valid && o_result.last))
        else $error("append result missing");

    // Remove transfer: busy through the compare and close-up states, then its final result
    a_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == olar_pkg::ACT_REMOVE)
        |=> busy ##1 busy ##1 (o_valid && o_result.last))
        else $error("remove sequence broken");

    // Only dump entries may be non-final
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != olar_pkg::ST_ENTRY) |-> o_result.last)
        else $error("non-entry result not marked last");

    // Dump stream has no gaps until its last entry
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("gap in dump stream");

endmodule

bind ordered_list_append_remove_top olar_chk u_olar_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the ordered list block: a directed table followed by
// weighted random appends, removes, dumps and unused codes, checked against a local list model.
// Depends on olar_pkg and ordered_list_append_remove_top.
module tb_top;

    localparam int          LIST_DEPTH  = olar_pkg::DEPTH_DEF;
    localparam int          RAND_ITEMS  = 500;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_TAIL  = 24;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    typedef struct {
        logic [1:0]         code;
        logic signed [31:0] value;
        int                 reps;
        bit                 typed;
        olar_pkg::t_status  want_status;
    } t_dir_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    olar_pkg::t_in   i_item;
    logic            busy;
    logic            o_valid;
    olar_pkg::t_out  o_result;

    // Local copy of the list contents, head at index 0
    logic signed [31:0] list_vals [LIST_DEPTH];
    int                 list_len;

    olar_pkg::t_out pending_results [$];
    t_dir_row       dir_rows [$];

    int error_count;
    int idle_cycles;
    int items_sent;
    int results_seen;
    int full_hits;
    int miss_hits;
    int empty_dumps;
    int dump_entries;

    ordered_list_append_remove_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Apply one command to the list model and queue the results it causes
    function automatic void apply_list_op(input olar_pkg::t_in cmd);
        olar_pkg::t_out res;
        int   hit;
        int   k;
        res.item_value = cmd.value;
        res.status     = olar_pkg::ST_DONE;
        res.last       = 1'b1;
        case (cmd.action)
            olar_pkg::ACT_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = olar_pkg::ST_FULL;
                    full_hits++;
                end else begin
                    list_vals[list_len] = cmd.value;
                    list_len++;
                end
                pending_results.push_back(res);
            end
            olar_pkg::ACT_REMOVE: begin
                hit = -1;
                for (k = 0; k < list_len; k++) begin
                    if (hit < 0 && list_vals[k] == cmd.value) hit = k;
                end
                if (hit < 0) begin
                    res.status = olar_pkg::ST_NOT_FOUND;
                    miss_hits++;
                end else begin
                    // close up the entries behind the match
                    for (k = hit; k + 1 < list_len; k++) list_vals[k] = list_vals[k + 1];
                    list_len--;
                end
                pending_results.push_back(res);
            end
            olar_pkg::ACT_DUMP: begin
                if (list_len == 0) begin
                    res.item_value = '0;
                    res.status     = olar_pkg::ST_EMPTY;
                    empty_dumps++;
                    pending_results.push_back(res);
                end else begin
                    for (k = 0; k < list_len; k++) begin
                        res.item_value = list_vals[k];
                        res.status     = olar_pkg::ST_ENTRY;
                        res.last       = (k + 1 == list_len);
                        pending_results.push_back(res);
                        dump_entries++;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Random operand: small values for duplicates, extremes, or any pattern
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $signed($urandom_range(0, 7)) - 4;
        if (sel == 4) return 32'sh7FFF_FFFF;
        if (sel == 5) return 32'sh8000_0000;
        return $signed($urandom);
    endfunction

    task automatic add_row(input logic [1:0] code, input logic signed [31:0] value,
                           input int reps, input bit typed, input olar_pkg::t_status want);
        t_dir_row row;
        row.code        = code;
        row.value       = value;
        row.reps        = reps;
        row.typed       = typed;
        row.want_status = want;
        dir_rows.push_back(row);
    endtask

    // Drive one command after a gap, hold it until the transfer, then predict
    task automatic send_item(input olar_pkg::t_in cmd, input int gap, input bit typed,
                             input olar_pkg::t_status want);
        olar_pkg::t_out fixed;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_list_op(cmd);
        if (cmd.action != olar_pkg::t_action'(ACT_UNUSED)) items_sent++;
        // replace the prediction by the value typed into the table
        if (typed) begin
            fixed.item_value = (want == olar_pkg::ST_EMPTY) ? '0 : cmd.value;
            fixed.status     = want;
            fixed.last       = 1'b1;
            void'(pending_results.pop_back());
            pending_results.push_back(fixed);
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        olar_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: item_value %0d status %0d last %0d",
                       o_result.item_value, o_result.status, o_result.last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.item_value !== want.item_value) begin
                    $error("item_value: expected %0d, actual %0d",
                           want.item_value, o_result.item_value);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    error_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_result.last);
                    error_count++;
                end
            end
        end
    end

    // Count cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("ordered_list_append_remove_top verification failed");
        $finish;
    end

    initial begin
        olar_pkg::t_in cmd;
        int  r;
        int  k;
        int  phase;
        int  append_w;
        int  remove_w;
        int  gap;
        bit  drained;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        list_len     = 0;
        error_count  = 0;
        idle_cycles  = 0;
        items_sent   = 0;
        results_seen = 0;
        full_hits    = 0;
        miss_hits    = 0;
        empty_dumps  = 0;
        dump_entries = 0;
        drained      = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed table: empty list, extremes, duplicates, full list, misses
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b1, olar_pkg::ST_EMPTY);
        add_row(olar_pkg::ACT_REMOVE, 32'sd5,         1, 1'b1, olar_pkg::ST_NOT_FOUND);
        add_row(olar_pkg::ACT_APPEND, 32'sh7FFF_FFFF, 1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, 32'sh8000_0000, 1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, -32'sd1,        1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, 32'sd0,         1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, -32'sd1,        1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b0, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_REMOVE, -32'sd1,        1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b0, olar_pkg::ST_DONE);
        add_row(ACT_UNUSED,           32'sh5A5A_5A5A, 1, 1'b0, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_REMOVE, 32'sh8000_0000, 1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_REMOVE, 32'sd12345,     1, 1'b1, olar_pkg::ST_NOT_FOUND);
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b0, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, 32'sd100,      13, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, -32'sd42,       1, 1'b1, olar_pkg::ST_FULL);
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b0, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_REMOVE, 32'sd112,       1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, 1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_APPEND, 32'sh8000_0000, 1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b0, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_REMOVE, -32'sd1,        1, 1'b1, olar_pkg::ST_DONE);
        add_row(olar_pkg::ACT_DUMP,   32'sd0,         1, 1'b0, olar_pkg::ST_DONE);

        foreach (dir_rows[i]) begin
            for (k = 0; k < dir_rows[i].reps; k++) begin
                cmd.action = olar_pkg::t_action'(dir_rows[i].code);
                cmd.value  = dir_rows[i].value + k;
                send_item(cmd, $urandom_range(0, 16), dir_rows[i].typed,
                          dir_rows[i].want_status);
            end
        end

        // Random part: alternate fill-heavy and drain-heavy phases
        r = 0;
        while (items_sent < RAND_ITEMS) begin
            phase    = (items_sent / 50) % 6;
            append_w = (phase % 2) ? 55 : 30;
            remove_w = (phase % 2) ? 25 : 40;
            r        = $urandom_range(0, 99);
            if (r < append_w) begin
                cmd.action = olar_pkg::ACT_APPEND;
                cmd.value  = pick_value();
            end else if (r < append_w + remove_w) begin
                cmd.action = olar_pkg::ACT_REMOVE;
                if (list_len > 0 && $urandom_range(0, 9) < 7)
                    cmd.value = list_vals[$urandom_range(0, list_len - 1)];
                else
                    cmd.value = pick_value();
            end else if (r < 97) begin
                cmd.action = olar_pkg::ACT_DUMP;
                cmd.value  = $signed($urandom);
            end else begin
                cmd.action = olar_pkg::t_action'(ACT_UNUSED);
                cmd.value  = $signed($urandom);
            end
            // back-to-back stretch in one phase out of three
            gap = (phase % 3 == 2) ? 0 : $urandom_range(0, 16);
            send_item(cmd, gap, 1'b0, olar_pkg::ST_DONE);
            if (!drained && items_sent >= 300) begin
                wait_drain();
                drained = 1'b1;
            end
        end

        // Drain outstanding results, then allow a tail for stray output
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Covered %0d commands and %0d results: %0d full appends, %0d misses,",
                 items_sent, results_seen, full_hits, miss_hits);
        $display("%0d empty dumps and %0d dumped entries.", empty_dumps, dump_entries);
        if (error_count == 0) begin
            $display("ordered_list_append_remove_top verification clean");
        end else begin
            $display("ordered_list_append_remove_top verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/olar_pkg.sv
sv/olar_ctrl.sv
sv/olar_dp.sv
sv/ordered_list_append_remove_top.sv
sv/olar_chk.sv
tb/tb_top.sv
